### rtl/rfc_pkg.sv
// Shared types and constants of the reader frame codec.
// Used by rfc_front, rfc_queue, rfc_back and the top level; depends on nothing.
package rfc_pkg;

  localparam logic [7:0] FRAME_MARK = 8'h60;

  // input item operations
  localparam logic [1:0] OP_HEADER  = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_RECV    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_RECV   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CARD    = 2'd1;
  localparam logic [1:0] ST_LRC     = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  localparam int MAX_RESULTS = 5;
  localparam int IDX_W       = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH = 4;

  // One queued job: up to five results sharing kind, status and length.
  typedef struct packed {
    logic [1:0]                  kind;
    logic [1:0]                  status;
    logic [15:0]                 flen;
    logic [IDX_W-1:0]            count;    // number of results, 1..5
    logic                        last_en;  // final result carries last
    logic [MAX_RESULTS-1:0][7:0] bytes;    // bytes[0] goes out first
  } rfc_rec_t;

  // Queue state seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic head_valid;
  } rfc_q_stat_t;

endpackage

### rtl/reader_frame_codec_lrc_unit.sv
// Reader frame codec with XOR LRC: request framing and response checking.
// The first result of an item passes through the job queue and then the output register.
// With out_tready high: one result, or one item of one result or none, per cycle.
// A header within the limit makes four or five results, so a burst of them
// backs up the job queue and holds in_tready low until the output side drains it.
// Reset (rst_n low, synchronous) clears parser state, queue and output valid.
module reader_frame_codec_lrc_unit #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command[7:0], length[23:8], data_byte[31:24],
                                  // first[32], zero fill [39:33]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // byte_out[7:0], status[9:8], frame_length[25:10],
                                  // zero fill [31:26]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast   // last
);

  logic                 acc;
  logic                 push;
  logic                 pop;
  rfc_pkg::rfc_rec_t    push_rec;
  rfc_pkg::rfc_rec_t    head_rec;
  rfc_pkg::rfc_q_stat_t q_stat;

  // Take a new item whenever the job queue has room; items with no result
  // wait for room as well.
  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;

  // Front: classify the item, advance the request and response state, and
  // build the job describing its results.
  rfc_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .op        (in_tuser),
    .command   (in_tdata[7:0]),
    .length    (in_tdata[23:8]),
    .data_byte (in_tdata[31:24]),
    .first     (in_tdata[32]),
    .push      (push),
    .rec       (push_rec)
  );

  // Queue: decouple item intake from result delivery.
  rfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  // Back: advance through the head job one result per transfer.
  rfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .stat       (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/rfc_front.sv
// Front part of the reader frame codec: accepts items, keeps request and
// response parser state, and turns each item into a job record. Uses rfc_pkg.
module rfc_front #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [1:0]        op,
  input  logic [7:0]        command,
  input  logic [15:0]       length,
  input  logic [7:0]        data_byte,
  input  logic              first,
  output logic              push,
  output rfc_pkg::rfc_rec_t rec
);

  localparam int IDX_W = rfc_pkg::IDX_W;

  localparam logic [16:0] LIMIT = 17'(BUFFER_BYTES - 5);

  localparam logic [2:0] PH_ACK     = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_CMD     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_LRC     = 3'd5;
  localparam logic [2:0] PH_DISCARD = 3'd6;

  logic [7:0]  send_lrc_r, send_lrc_nxt;
  logic [15:0] send_rem_r, send_rem_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] rpos_r, rpos_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [7:0]  rlrc_r, rlrc_nxt;
  logic [7:0]  rack_r, rack_nxt;

  logic [2:0]  phase_eff;
  logic [7:0]  hdr_lrc;
  logic [15:0] rlen_full;
  logic [15:0] rpos_inc;
  logic        has_res;

  assign phase_eff = first ? PH_ACK : phase_r;
  assign hdr_lrc   = rfc_pkg::FRAME_MARK ^ length[15:8] ^ length[7:0] ^ command;
  assign rlen_full = {rlen_r[15:8], data_byte};
  assign rpos_inc  = rpos_r + 16'd1;

  always_comb begin
    send_lrc_nxt = send_lrc_r;
    send_rem_nxt = send_rem_r;
    phase_nxt    = phase_r;
    rpos_nxt     = rpos_r;
    rlen_nxt     = rlen_r;
    rlrc_nxt     = rlrc_r;
    rack_nxt     = rack_r;
    has_res      = 1'b0;
    rec          = '0;
    rec.count    = IDX_W'(1);

    unique case (op)
      rfc_pkg::OP_HEADER: begin
        has_res = 1'b1;
        if ({1'b0, length} > LIMIT) begin
          send_rem_nxt = '0;
          rec.kind     = rfc_pkg::KIND_STATUS;
          rec.status   = rfc_pkg::ST_TOOLONG;
          rec.last_en  = 1'b1;
        end else begin
          send_lrc_nxt = hdr_lrc;
          send_rem_nxt = length;
          rec.kind     = rfc_pkg::KIND_SEND;
          rec.bytes[0] = rfc_pkg::FRAME_MARK;
          rec.bytes[1] = length[15:8];
          rec.bytes[2] = length[7:0];
          rec.bytes[3] = command;
          rec.bytes[4] = hdr_lrc;
          rec.last_en  = (length == 16'd0);
          rec.count    = (length == 16'd0) ? IDX_W'(5) : IDX_W'(4);
        end
      end
      rfc_pkg::OP_PAYLOAD: begin
        if (send_rem_r != 16'd0) begin
          has_res      = 1'b1;
          send_lrc_nxt = send_lrc_r ^ data_byte;
          send_rem_nxt = send_rem_r - 16'd1;
          rec.kind     = rfc_pkg::KIND_SEND;
          rec.bytes[0] = data_byte;
          rec.bytes[1] = send_lrc_r ^ data_byte;
          rec.last_en  = (send_rem_r == 16'd1);
          rec.count    = (send_rem_r == 16'd1) ? IDX_W'(2) : IDX_W'(1);
        end
      end
      rfc_pkg::OP_RECV: begin
        unique case (phase_eff)
          PH_ACK: begin
            rack_nxt  = data_byte;
            rlrc_nxt  = data_byte;
            rlen_nxt  = '0;
            rpos_nxt  = '0;
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            rlrc_nxt  = rlrc_r ^ data_byte;
            rlen_nxt  = {data_byte, 8'd0};
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            rlrc_nxt = rlrc_r ^ data_byte;
            rlen_nxt = rlen_full;
            if ({1'b0, rlen_full} > LIMIT) begin
              phase_nxt   = PH_DISCARD;
              has_res     = 1'b1;
              rec.kind    = rfc_pkg::KIND_STATUS;
              rec.status  = rfc_pkg::ST_TOOLONG;
              rec.last_en = 1'b1;
            end else begin
              phase_nxt = PH_CMD;
            end
          end
          PH_CMD: begin
            rlrc_nxt  = rlrc_r ^ data_byte;
            rpos_nxt  = '0;
            phase_nxt = (rlen_r == 16'd0) ? PH_LRC : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            rlrc_nxt     = rlrc_r ^ data_byte;
            rpos_nxt     = rpos_inc;
            has_res      = 1'b1;
            rec.kind     = rfc_pkg::KIND_RECV;
            rec.bytes[0] = data_byte;
            if (rpos_inc >= rlen_r) begin
              phase_nxt = PH_LRC;
            end
          end
          PH_LRC: begin
            has_res     = 1'b1;
            rec.kind    = rfc_pkg::KIND_STATUS;
            rec.last_en = 1'b1;
            phase_nxt   = PH_ACK;
            if ((rlrc_r ^ data_byte) != 8'd0) begin
              rec.status = rfc_pkg::ST_LRC;
            end else if (rack_r != rfc_pkg::FRAME_MARK) begin
              rec.status = rfc_pkg::ST_CARD;
              rec.flen   = rlen_r;
            end else begin
              rec.status = rfc_pkg::ST_OK;
              rec.flen   = rlen_r;
            end
          end
          default: begin
            // discard until the next frame start
          end
        endcase
      end
      default: begin
        // unused op: no result, no state change
      end
    endcase
  end

  assign push = acc && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_lrc_r <= '0;
      send_rem_r <= '0;
      phase_r    <= PH_ACK;
      rpos_r     <= '0;
      rlen_r     <= '0;
      rlrc_r     <= '0;
      rack_r     <= '0;
    end else if (acc) begin
      send_lrc_r <= send_lrc_nxt;
      send_rem_r <= send_rem_nxt;
      phase_r    <= phase_nxt;
      rpos_r     <= rpos_nxt;
      rlen_r     <= rlen_nxt;
      rlrc_r     <= rlrc_nxt;
      rack_r     <= rack_nxt;
    end
  end

endmodule

### rtl/rfc_queue.sv
// Short job queue between front and back of the reader frame codec.
// Register array with read and write pointers. Uses rfc_pkg.
module rfc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rfc_pkg::rfc_rec_t   push_rec,
  input  logic                pop,
  output rfc_pkg::rfc_rec_t   head_rec,
  output rfc_pkg::rfc_q_stat_t stat
);

  localparam int DEPTH = rfc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfc_pkg::rfc_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign stat.full       = (cnt_r == CNT_W'(DEPTH));
  assign stat.head_valid = (cnt_r != '0);
  assign head_rec        = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_rec;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.head_valid)
    else $error("queue read while empty");
`endif

endmodule

### rtl/rfc_back.sv
// Back part of the reader frame codec: expands queued jobs into results,
// one per cycle while out_tready allows, into the output register. Uses rfc_pkg.
module rfc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rfc_pkg::rfc_rec_t    head_rec,
  input  rfc_pkg::rfc_q_stat_t stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [1:0]           out_tuser,
  output logic [31:0]          out_tdata,
  output logic                 out_tlast
);

  localparam int IDX_W = rfc_pkg::IDX_W;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic [1:0]       kind_r;
  logic [7:0]       byte_r;
  logic [1:0]       status_r;
  logic [15:0]      flen_r;
  logic             last_r;
  logic             load;
  logic             at_end;

  assign load   = stat.head_valid && (!vld_r || out_tready);
  assign at_end = (idx_r == head_rec.count - IDX_W'(1));
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = at_end ? '0 : idx_r + IDX_W'(1);
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= head_rec.kind;
      byte_r   <= head_rec.bytes[idx_r];
      status_r <= head_rec.status;
      flen_r   <= head_rec.flen;
      last_r   <= head_rec.last_en && at_end;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {6'd0, flen_r, status_r, byte_r};
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_partial_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> stat.head_valid)
    else $error("job left the queue before all its results went out");
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == rfc_pkg::KIND_STATUS) |-> out_tlast)
    else $error("status result without last");
`endif

endmodule
